// ===== rtl/cle_pkg.sv =====
package cle_pkg;

   // fixed field widths
   localparam int CHAR_W      = 7;
   localparam int CODE_W      = 8;
   localparam int KIND_W      = 3;
   localparam int FILL_W      = 6;
   localparam int TICK_W      = 16;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // default line memory depth
   localparam int LINE_DEPTH_DEF = 32;

   // register reset values
   localparam logic              TIMEOUT_ENABLE_RST = 1'b0;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST  = 16'd500;
   localparam logic [FILL_W-1:0] LINE_SIZE_RST      = 6'd32;

   // register indexes
   localparam logic [1:0] REG_TIMEOUT_ENABLE = 2'd0;
   localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd1;
   localparam logic [1:0] REG_LINE_SIZE      = 2'd2;

   // control characters
   localparam logic [CHAR_W-1:0] CH_CR  = 7'h0D;
   localparam logic [CHAR_W-1:0] CH_NL  = 7'h0A;
   localparam logic [CHAR_W-1:0] CH_DEL = 7'h7F;
   localparam logic [CHAR_W-1:0] CH_BS  = 7'h08;
   localparam logic [CHAR_W-1:0] CH_NAK = 7'h15;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ECHO    = 3'd0,
      KIND_CHAR    = 3'd1,
      KIND_END     = 3'd2,
      KIND_KILL    = 3'd3,
      KIND_TIMEOUT = 3'd4,
      KIND_LONG    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ECHO,
      ST_CHAR,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic              timeout_enable;
      logic [TICK_W-1:0] timeout_ticks;
      logic [FILL_W-1:0] line_size;
   } cfg_type;

endpackage

// ===== rtl/cle_if.sv =====
interface cle_req_if import cle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [CODE_W-1:0] char_code;

   modport source (output valid, output req_type, output char_code, input ready);
   modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface cle_rsp_if import cle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [CHAR_W-1:0] value;
   logic [FILL_W-1:0] length;
   logic              last;

   modport source (output valid, output kind, output value, output length, output last,
                   input ready);
   modport sink   (input valid, input kind, input value, input length, input last,
                   output ready);
endinterface

// ===== rtl/cle_ram.sv =====
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cle_csr.sv =====
module cle_csr import cle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TIMEOUT_ENABLE: cfg_in.timeout_enable = csr_pwdata[0];
            REG_TIMEOUT_TICKS:  cfg_in.timeout_ticks  = csr_pwdata[TICK_W-1:0];
            REG_LINE_SIZE:      cfg_in.line_size      = csr_pwdata[FILL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_enable <= TIMEOUT_ENABLE_RST;
         cfg_ff.timeout_ticks  <= TIMEOUT_TICKS_RST;
         cfg_ff.line_size      <= LINE_SIZE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // readback
   always_comb begin
      case (reg_idx)
         REG_TIMEOUT_ENABLE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.timeout_enable};
         REG_TIMEOUT_TICKS:  csr_prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, cfg_ff.timeout_ticks};
         REG_LINE_SIZE:      csr_prdata = {{(CSR_DATA_W-FILL_W){1'b0}}, cfg_ff.line_size};
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/cle_engine.sv =====
module cle_engine import cle_pkg::*; #(
   parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   cle_req_if.sink   req_if,
   cle_rsp_if.source rsp_if
);

   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(LINE_DEPTH);

   state_type          state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [TICK_W-1:0]  idle_ff, idle_in;
   logic [CHAR_W-1:0]  cur_ff, cur_in;
   kind_type           fkind_ff, fkind_in;
   logic [FILL_W-1:0]  flen_ff, flen_in;
   logic [FILL_W-1:0]  dump_idx_ff, dump_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [FILL_W-1:0]  rsp_length_ff, rsp_length_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               slot_free;
   logic [CHAR_W-1:0]  in_char;
   logic [CHAR_W-1:0]  mapped;
   logic [TICK_W-1:0]  idle_inc;
   logic               timeout_hit;
   logic [FILL_W-1:0]  eff_size;
   logic               is_store;
   logic [FILL_W-1:0]  dump_next;

   logic               mem_we;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [CHAR_W-1:0]  mem_rdata;

   cle_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (fill_ff[ADDR_W-1:0]),
      .wdata (cur_ff),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;

   // character translation
   assign in_char = req_if.char_code[CHAR_W-1:0];
   always_comb begin
      case (in_char)
         CH_CR:   mapped = CH_NL;
         CH_DEL:  mapped = CH_BS;
         default: mapped = in_char;
      endcase
   end

   // idle counter with saturation, then compare
   assign idle_inc    = (idle_ff == {TICK_W{1'b1}}) ? idle_ff : idle_ff + TICK_W'(1);
   assign timeout_hit = cfg.timeout_enable && (idle_inc > cfg.timeout_ticks);

   assign eff_size  = (cfg.line_size > DEPTH_F) ? DEPTH_F : cfg.line_size;
   assign is_store  = (cur_ff != CH_BS) && (cur_ff != CH_NL) && (cur_ff != CH_NAK)
                      && (fill_ff < eff_size);
   assign dump_next = dump_idx_ff + FILL_W'(1);

   // sequencer: next state, memory access and result staging
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      idle_in       = idle_ff;
      cur_in        = cur_ff;
      fkind_in      = fkind_ff;
      flen_in       = flen_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = dump_next[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.req_type == REQ_TICK) begin
                  idle_in = idle_inc;
                  if (timeout_hit) begin
                     fkind_in = KIND_TIMEOUT;
                     flen_in  = '0;
                     fill_in  = '0;
                     idle_in  = '0;
                     state_in = ST_FINAL;
                  end
               end else begin
                  idle_in  = '0;
                  cur_in   = mapped;
                  state_in = ST_ECHO;
               end
            end
         end
         ST_ECHO: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ECHO;
               rsp_value_in  = (cur_ff == CH_NAK) ? CH_NL : cur_ff;
               rsp_length_in = '0;
               rsp_last_in   = (cur_ff == CH_BS) || is_store;
               state_in      = ST_FINAL;
               if (cur_ff == CH_BS) begin
                  if (fill_ff != '0) begin
                     fill_in = fill_ff - FILL_W'(1);
                  end
                  state_in = ST_IDLE;
               end else if (cur_ff == CH_NL) begin
                  fkind_in = KIND_END;
                  flen_in  = fill_ff;
                  fill_in  = '0;
                  if (fill_ff != '0) begin
                     mem_re      = 1'b1;
                     mem_raddr   = '0;
                     dump_idx_in = '0;
                     state_in    = ST_CHAR;
                  end
               end else if (cur_ff == CH_NAK) begin
                  fkind_in = KIND_KILL;
                  flen_in  = '0;
                  fill_in  = '0;
               end else if (!is_store) begin
                  fkind_in = KIND_LONG;
                  flen_in  = eff_size;
                  fill_in  = '0;
               end else begin
                  mem_we   = 1'b1;
                  fill_in  = fill_ff + FILL_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CHAR: begin
            // read data for dump_idx is waiting; fetch the next entry on push
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_CHAR;
               rsp_value_in  = mem_rdata;
               rsp_length_in = '0;
               rsp_last_in   = 1'b0;
               dump_idx_in   = dump_next;
               if (dump_next == flen_ff) begin
                  state_in = ST_FINAL;
               end else begin
                  mem_re = 1'b1;
               end
            end
         end
         ST_FINAL: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = fkind_ff;
               rsp_value_in  = '0;
               rsp_length_in = flen_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      fkind_ff      <= fkind_in;
      flen_ff       <= flen_in;
      dump_idx_ff   <= dump_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.kind   = rsp_kind_ff;
   assign rsp_if.value  = rsp_value_ff;
   assign rsp_if.length = rsp_length_ff;
   assign rsp_if.last   = rsp_last_ff;

   // a store never lands past the effective line size
   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (fill_ff < eff_size))
      else $error("line store write beyond line size");

   // an accepted character always goes to the echo step
   a_char_to_echo: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.req_type == REQ_CHAR) |=> (state_ff == ST_ECHO))
      else $error("character not followed by echo");

   // the dump index stays below the captured line length
   a_dump_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHAR) |-> (dump_idx_ff < flen_ff))
      else $error("dump index past line length");

   // staging the final result of a transaction returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && slot_free && rsp_valid_in && rsp_last_in)
      |=> (state_ff == ST_IDLE))
      else $error("last result without return to idle");

endmodule

// ===== rtl/console_line_editor_top.sv =====
// Console line editor: takes received characters and timer ticks on req_if and gives
// echo, line character, line-end, kill, timeout and overlong results on rsp_if, one
// transaction per result, with last set on the final result of each input. A stored
// character or an erase gives only its echo once the result register is free (accept,
// then echo); a kill or an overlong character adds its end result, and a newline adds
// each stored character, read one entry a cycle from the line memory while the result
// register is free, and then the line end. A tick gives a result only when it ends the
// line by timeout. Inputs are taken only while the sequencer is idle; the result
// register lets the last result wait for the consumer while the next input is accepted.
// The line memory needs no clearing after reset: only entries written in the current
// line are read. Registers on the csr_ port: timeout_enable at 0x0, timeout_ticks at
// 0x4, line_size at 0x8; write them only while the block is idle.
module console_line_editor_top import cle_pkg::*; #(
   parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cle_req_if.sink               req_if,
   cle_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   // configuration registers
   cle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // line editing sequencer with line memory
   cle_engine #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule
